// ----- design/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An expression that must hold at every clock edge outside reset.
`define RCBA_ASSERT_HOLD(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("allocator invariant violated");

// A condition that must be followed by a consequence in the next cycle.
`define RCBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator next-cycle check failed");

`endif

// ----- design/rcba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes for the buffer index allocator.
// No dependencies; imported by the free stack, the top level and the testbench.
package rcba_pkg;

    // Capacity and field widths.
    localparam int MAX_BUFS = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 15;
    localparam int USED_W   = 7;

    // Request kinds.
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_COUNT = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [USED_W-1:0] used_t;

    // Commands from the request logic to the free stack.
    typedef struct packed {
        logic push;
        logic pop;
        idx_t push_idx;
    } stack_ctl_t;

endpackage

// ----- design/rcba_free_stack.sv -----
`timescale 1ns / 1ps
// LIFO free stack of released indices with the top entry held in a register.
// Depends on rcba_pkg for widths and the stack command struct.
module rcba_free_stack
    import rcba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stack_ctl_t ctl,
    output used_t      depth,
    output idx_t       tos
);

    idx_t  stack_mem [MAX_BUFS];
    used_t depth_reg;
    used_t depth_next;
    idx_t  tos_reg;
    idx_t  tos_next;
    idx_t  nos_reg;
    used_t rd_ptr;
    idx_t  rd_addr;

    // Depth after this cycle's push or pop; both never come together.
    always_comb
    begin
        depth_next = depth_reg;
        if (ctl.push)
        begin
            depth_next = depth_reg + USED_W'(1);
        end
        else if (ctl.pop)
        begin
            depth_next = depth_reg - USED_W'(1);
        end
    end

    // The new top is the pushed index, or the prefetched second entry on a pop.
    always_comb
    begin
        tos_next = tos_reg;
        if (ctl.push)
        begin
            tos_next = ctl.push_idx;
        end
        else if (ctl.pop)
        begin
            tos_next = nos_reg;
        end
    end

    // Prefetch the entry just below the next top; unused while depth is below two.
    assign rd_ptr  = depth_next - USED_W'(2);
    assign rd_addr = rd_ptr[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
    end

    // Stack storage: push writes at the current depth, the prefetch read is registered.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            stack_mem[depth_reg[IDX_W-1:0]] <= ctl.push_idx;
        end
        nos_reg <= stack_mem[rd_addr];
    end

    assign depth = depth_reg;
    assign tos   = tos_reg;

endmodule

// ----- design/ref_counted_buffer_index_allocator.sv -----
`timescale 1ns / 1ps
// Reference-counted buffer index allocator: top level with the count store.
// Depends on rcba_pkg, rcba_free_stack and assert_macros.svh.
// Path: a taken request is held in the request stage, and its result then in the output register.
// Throughput: one request per cycle unless m_tready stalls it; the count read has write bypass.
// Reset: asynchronous, clears the fill count, stack depth and valid flags; counts at or above
// the fill count read as zero, so no clearing pass is needed and requests are taken at once.
`include "assert_macros.svh"

module ref_counted_buffer_index_allocator
    import rcba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [14:0] use_count, [20:15] buf_index, [23:21] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [5:0] granted_index, [7:6] status, [14:8] buffers_used,
                                   // [15] zero
);

    // Request stage.
    logic  a_valid_reg;
    logic  a_kind_reg;
    cnt_t  a_count_reg;
    idx_t  a_idx_reg;
    cnt_t  cnt_rd_reg;
    logic  accept;
    logic  advance;
    cnt_t  s_count;
    idx_t  s_idx;

    // Count store.
    cnt_t  cnt_mem [MAX_BUFS];
    logic  cnt_wr_en;
    idx_t  cnt_wr_addr;
    cnt_t  cnt_wr_data;

    // Allocation state and results.
    used_t next_fresh_reg;
    used_t next_fresh_next;
    stack_ctl_t stack_ctl;
    used_t stack_depth;
    idx_t  stack_tos;
    cnt_t  cnt_cur;
    idx_t  granted_next;
    logic [1:0] status_next;

    // Result register.
    logic  m_valid_reg;
    idx_t  m_granted_reg;
    logic [1:0] m_status_reg;
    used_t m_used_reg;

    assign s_count  = s_tdata[CNT_W-1:0];
    assign s_idx    = s_tdata[CNT_W+IDX_W-1:CNT_W];
    assign advance  = a_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Request stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    // Request payload and count read; a write in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg  <= s_tuser;
            a_count_reg <= s_count;
            a_idx_reg   <= s_idx;
            if (cnt_wr_en && (cnt_wr_addr == s_idx))
            begin
                cnt_rd_reg <= cnt_wr_data;
            end
            else
            begin
                cnt_rd_reg <= cnt_mem[s_idx];
            end
        end
    end

    // Count store write port.
    always_ff @(posedge clk)
    begin
        if (cnt_wr_en)
        begin
            cnt_mem[cnt_wr_addr] <= cnt_wr_data;
        end
    end

    // An index at or above the fill count was never written and holds count zero.
    assign cnt_cur = ({1'b0, a_idx_reg} < next_fresh_reg) ? cnt_rd_reg : '0;

    // Allocate or release decision for the request in the stage.
    always_comb
    begin
        next_fresh_next    = next_fresh_reg;
        stack_ctl.push     = 1'b0;
        stack_ctl.pop      = 1'b0;
        stack_ctl.push_idx = a_idx_reg;
        cnt_wr_en          = 1'b0;
        cnt_wr_addr        = a_idx_reg;
        cnt_wr_data        = cnt_cur - CNT_W'(1);
        granted_next       = '0;
        status_next        = ST_OK;
        if (a_kind_reg == KIND_ALLOC)
        begin
            if (stack_depth != '0)
            begin
                stack_ctl.pop = advance;
                granted_next  = stack_tos;
                cnt_wr_en     = advance;
                cnt_wr_addr   = stack_tos;
                cnt_wr_data   = a_count_reg;
            end
            else if (next_fresh_reg != USED_W'(MAX_BUFS))
            begin
                next_fresh_next = next_fresh_reg + USED_W'(1);
                granted_next    = next_fresh_reg[IDX_W-1:0];
                cnt_wr_en       = advance;
                cnt_wr_addr     = next_fresh_reg[IDX_W-1:0];
                cnt_wr_data     = a_count_reg;
            end
            else
            begin
                status_next = ST_FULL;
            end
        end
        else
        begin
            if (cnt_cur == '0)
            begin
                status_next = ST_ZERO_COUNT;
            end
            else
            begin
                cnt_wr_en      = advance;
                stack_ctl.push = advance && (cnt_cur == CNT_W'(1));
            end
        end
    end

    rcba_free_stack u_free_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stack_ctl),
        .depth (stack_depth),
        .tos   (stack_tos)
    );

    // Fill count: the number of indices ever handed out, which is also the next never-used index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_fresh_reg <= '0;
        end
        else if (advance)
        begin
            next_fresh_reg <= next_fresh_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_granted_reg <= granted_next;
            m_status_reg  <= status_next;
            m_used_reg    <= next_fresh_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_used_reg, m_status_reg, m_granted_reg};

    // The free stack never holds more entries than indices handed out so far.
    `RCBA_ASSERT_HOLD(a_depth_within_fresh, stack_depth <= next_fresh_reg)
    // The fill count never moves backward.
    `RCBA_ASSERT_NEXT(a_fresh_monotonic, 1'b1, next_fresh_reg >= $past(next_fresh_reg))
    // A full report is only given once every index has been handed out.
    `RCBA_ASSERT_HOLD(a_full_only_at_capacity,
        !(m_valid_reg && (m_status_reg == ST_FULL)) || (m_used_reg == USED_W'(MAX_BUFS)))

endmodule

// ----- dv/ref_counted_buffer_index_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the reference-counted buffer index allocator.
// Depends on rcba_pkg and the ref_counted_buffer_index_allocator top level.
// Drives directed and random allocate/release requests and checks each reply.
module ref_counted_buffer_index_allocator_tb;
    import rcba_pkg::*;

    localparam int PLAN_BANK      = 0;
    localparam int CHECK_BANK     = 1;
    localparam int RANDOM_ITEMS   = 650;
    localparam int HOLD_AFTER     = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int TIMEOUT_CYCLES = 200000;

    typedef struct packed {
        logic kind;
        cnt_t cnt;
        idx_t idx;
    } alloc_req_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // [14:0] use_count, [20:15] buf_index, [23:21] zero
    logic        s_tuser  = 1'b0; // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [5:0] granted_index, [7:6] status, [14:8] buffers_used,
                                 // [15] zero

    // Two copies of the allocator state: one steers the generator, one checks.
    cnt_t ref_cnt [2][MAX_BUFS];
    idx_t free_lifo [2][MAX_BUFS];
    int   lifo_depth [2];
    int   fresh_next [2];

    alloc_req_t  request_backlog[$];
    logic [15:0] reply_words_due[$];
    alloc_req_t  next_req;

    int burst_left  = 0;
    int gap_left    = 0;
    int rx_mode     = 0;
    int rx_span     = 0;
    int rx_phase    = 0;
    int hold_left   = 0;
    bit hold_used   = 1'b0;
    int replies_seen = 0;
    int cycle_count = 0;
    int errors      = 0;
    logic [15:0] want;

    ref_counted_buffer_index_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 4 ns period.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Apply one request to a state bank and return the packed reply word.
    function automatic logic [15:0] allocate_or_release(input int bank, input logic kind,
                                                        input cnt_t cnt, input idx_t idx);
        idx_t       granted;
        logic [1:0] status;
        idx_t       slot;
        granted = '0;
        status  = ST_OK;
        if (kind == KIND_ALLOC)
        begin
            if (lifo_depth[bank] > 0)
            begin
                lifo_depth[bank] = lifo_depth[bank] - 1;
                slot = free_lifo[bank][lifo_depth[bank]];
                ref_cnt[bank][slot] = cnt;
                granted = slot;
            end
            else if (fresh_next[bank] < MAX_BUFS)
            begin
                slot = idx_t'(fresh_next[bank]);
                fresh_next[bank] = fresh_next[bank] + 1;
                ref_cnt[bank][slot] = cnt;
                granted = slot;
            end
            else
            begin
                status = ST_FULL;
            end
        end
        else if (ref_cnt[bank][idx] == '0)
        begin
            status = ST_ZERO_COUNT;
        end
        else
        begin
            ref_cnt[bank][idx] = ref_cnt[bank][idx] - 1'b1;
            // A count that drops to zero returns its index to the top of the stack.
            if (ref_cnt[bank][idx] == '0 && lifo_depth[bank] < MAX_BUFS)
            begin
                free_lifo[bank][lifo_depth[bank]] = idx;
                lifo_depth[bank] = lifo_depth[bank] + 1;
            end
        end
        return {1'b0, used_t'(fresh_next[bank]), status, granted};
    endfunction

    // Queue a request and advance the generator's view of the state.
    task automatic queue_request(input logic kind, input cnt_t cnt, input idx_t idx);
        logic [15:0] unused_reply;
        unused_reply = allocate_or_release(PLAN_BANK, kind, cnt, idx);
        request_backlog.push_back('{kind: kind, cnt: cnt, idx: idx});
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reply_words_due.push_back(allocate_or_release(CHECK_BANK, s_tuser,
                                                              s_tdata[14:0], s_tdata[20:15]));
            end
            // A request that was not taken stays on the bus unchanged.
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (request_backlog.size() != 0)
                begin
                    next_req = request_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, next_req.idx, next_req.cnt};
                    s_tuser  <= next_req.kind;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that changes mode after each random span.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_mode      <= 0;
            rx_span      <= 0;
            rx_phase     <= 0;
            replies_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                replies_seen <= replies_seen + 1;
                if (reply_words_due.size() == 0)
                begin
                    $display("%0t: reply with no request outstanding, actual %h", $time,
                             m_tdata);
                    errors = errors + 1;
                end
                else
                begin
                    want = reply_words_due.pop_front();
                    if (m_tdata[5:0] != want[5:0])
                    begin
                        $display("%0t: granted_index expected %0d actual %0d", $time,
                                 want[5:0], m_tdata[5:0]);
                        errors = errors + 1;
                    end
                    if (m_tdata[7:6] != want[7:6])
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want[7:6], m_tdata[7:6]);
                        errors = errors + 1;
                    end
                    if (m_tdata[14:8] != want[14:8])
                    begin
                        $display("%0t: buffers_used expected %0d actual %0d", $time,
                                 want[14:8], m_tdata[14:8]);
                        errors = errors + 1;
                    end
                end
            end
            if (rx_span == 0)
            begin
                rx_mode <= $urandom_range(0, 2);
                rx_span <= $urandom_range(10, 60);
            end
            else
            begin
                rx_span <= rx_span - 1;
            end
            rx_phase <= rx_phase + 1;
            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (rx_mode == 0)
                m_tready <= 1'b1;
            else if (rx_mode == 1)
                m_tready <= 1'($urandom_range(0, 1));
            else
                m_tready <= (rx_phase % 4 == 0);
        end
    end

    // One long hold-off on the reply side so that the block backs up its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_used && replies_seen >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count == TIMEOUT_CYCLES);
        $display("** ref_counted_buffer_index_allocator: FAILED **");
        $finish;
    end

    // Reset, stimulus generation and end of run.
    initial
    begin
        int   made;
        int   bias;
        int   span;
        int   pick;
        int   held_n;
        idx_t held_list [MAX_BUFS];
        logic kind;
        cnt_t cnt;
        idx_t idx;

        for (int b = 0; b < 2; b++)
        begin
            lifo_depth[b] = 0;
            fresh_next[b] = 0;
            for (int i = 0; i < MAX_BUFS; i++)
            begin
                ref_cnt[b][i]   = '0;
                free_lifo[b][i] = '0;
            end
        end

        // Directed: releases of never-allocated indices, reuse order and held indices.
        queue_request(KIND_RELEASE, 15'd0, 6'd0);
        queue_request(KIND_RELEASE, 15'h7FFF, 6'd63);
        queue_request(KIND_ALLOC, 15'd1, 6'd63);
        queue_request(KIND_RELEASE, 15'd0, 6'd0);
        queue_request(KIND_ALLOC, 15'h7FFF, 6'd0);
        // Allocate with a zero count: the index can never be released.
        queue_request(KIND_ALLOC, 15'd0, 6'd42);
        queue_request(KIND_RELEASE, 15'd0, 6'd1);
        queue_request(KIND_ALLOC, 15'd2, 6'd0);
        queue_request(KIND_RELEASE, 15'h7FFF, 6'd2);
        queue_request(KIND_RELEASE, 15'd0, 6'd2);
        queue_request(KIND_RELEASE, 15'd0, 6'd2);
        queue_request(KIND_ALLOC, 15'd1, 6'd21);
        queue_request(KIND_ALLOC, 15'd1, 6'd0);
        queue_request(KIND_ALLOC, 15'd1, 6'd0);
        // Free 3 then 4; the next two allocations must return 4 then 3.
        queue_request(KIND_RELEASE, 15'd0, 6'd3);
        queue_request(KIND_RELEASE, 15'd0, 6'd4);
        queue_request(KIND_ALLOC, 15'h5555, 6'd0);
        queue_request(KIND_ALLOC, 15'h2AAA, 6'd0);
        queue_request(KIND_RELEASE, 15'd0, 6'd4);

        // Random rounds; the first one is allocation-heavy and runs the block full.
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            if (made == 0)
            begin
                bias = 95;
                span = 120;
            end
            else
            begin
                pick = $urandom_range(0, 2);
                bias = (pick == 0) ? 25 : (pick == 1) ? 55 : 85;
                span = $urandom_range(40, 100);
            end
            // The last round is cut short so the total stays at the planned count.
            if (span > RANDOM_ITEMS - made)
                span = RANDOM_ITEMS - made;
            repeat (span)
            begin
                kind = ($urandom_range(0, 99) < bias) ? KIND_ALLOC : KIND_RELEASE;
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    cnt = '0;
                else if (pick < 10)
                    cnt = 15'h7FFF;
                else if (pick < 20)
                    cnt = cnt_t'($urandom_range(0, 32767));
                else
                    cnt = cnt_t'($urandom_range(1, 3));
                idx = idx_t'($urandom_range(0, 63));
                // Most releases target an index that still holds references.
                if (kind == KIND_RELEASE && $urandom_range(0, 99) < 85)
                begin
                    held_n = 0;
                    for (int i = 0; i < MAX_BUFS; i++)
                    begin
                        if (ref_cnt[PLAN_BANK][i] != '0)
                        begin
                            held_list[held_n] = idx_t'(i);
                            held_n = held_n + 1;
                        end
                    end
                    if (held_n > 0)
                        idx = held_list[$urandom_range(0, held_n - 1)];
                end
                queue_request(kind, cnt, idx);
                made = made + 1;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!(request_backlog.size() == 0 && !s_tvalid && reply_words_due.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (reply_words_due.size() != 0)
        begin
            $display("%0t: %0d replies still outstanding, expected none", $time,
                     reply_words_due.size());
            errors = errors + 1;
        end
        if (errors == 0)
            $display("** ref_counted_buffer_index_allocator: PASSED **");
        else
            $display("** ref_counted_buffer_index_allocator: FAILED **");
        $finish;
    end

endmodule
